@@ sv/bpa_pkg.sv @@
`default_nettype none
// shared constants, codes and handoff types of the buddy page allocator
package bpa_pkg;

    localparam int MAX_PAGES_DEF = 1024;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 10;
    localparam int CNT_W    = 11;

    localparam logic [CNT_W-1:0] PAGES_RST = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]    pages_left;
        logic [CNT_W-1:0]    block_pages;
        logic [OFF_W-1:0]    result_offset;
        logic [STATUS_W-1:0] status;
    } bpa_res_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] pages_left;
        logic [CNT_W-1:0] managed;
    } bpa_stat_t;

endpackage
`default_nettype wire

@@ sv/bpa_engine.sv @@
`default_nettype none
// tree memory and command sequencer of the buddy page allocator
module bpa_engine import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire [CMD_W-1:0]     cmd,
    input  wire [CNT_W-1:0]     page_count,
    input  wire [OFF_W-1:0]     block_offset,
    input  wire [CNT_W-1:0]     pages_in_use,
    output logic                res_valid,
    input  wire                 res_take,
    output bpa_res_t            res,
    output bpa_stat_t           stat
);

    localparam int LW    = $clog2(MAX_PAGES);
    localparam int SW    = LW + 1;
    localparam int NW    = LW + 1;
    localparam int NODES = 2 * MAX_PAGES - 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADESC  = 3'd1;
    localparam logic [2:0] S_AUP    = 3'd2;
    localparam logic [2:0] S_FCLIMB = 3'd3;
    localparam logic [2:0] S_FUP    = 3'd4;
    localparam logic [2:0] S_INIT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    function automatic logic [31:0] smear(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        v = v | (v >> 1);
        v = v | (v >> 2);
        v = v | (v >> 4);
        v = v | (v >> 8);
        v = v | (v >> 16);
        return v;
    endfunction

    function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] i);
        return ((i + NW'(1)) >> 1) - NW'(1);
    endfunction

    function automatic logic [NW-1:0] sibling_of(input logic [NW-1:0] i);
        return i[0] ? (i + NW'(1)) : (i - NW'(1));
    endfunction

    function automatic logic [SW-1:0] larger(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [SW-1:0] tree_mem [0:NODES-1];
    logic [SW-1:0] rd_data_reg;

    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [NW-1:0] mem_raddr;

    logic [2:0]          state_reg,      state_next;
    logic [SW-1:0]       managed_reg,    managed_next;
    logic [SW-1:0]       free_reg,       free_next;
    logic [SW-1:0]       root_reg,       root_next;
    logic [NW-1:0]       idx_reg,        idx_next;
    logic [SW-1:0]       ns_reg,         ns_next;
    logic [SW-1:0]       size_reg,       size_next;
    logic [LW-1:0]       off_reg,        off_next;
    logic [SW-1:0]       val_reg,        val_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [LW-1:0]       res_off_reg,    res_off_next;
    logic [SW-1:0]       res_pages_reg,  res_pages_next;

    logic [31:0]   req32;
    logic [31:0]   cap32;
    logic [31:0]   span32;
    logic [31:0]   init32;
    logic [NW-1:0] lchild;
    logic          go_left;
    logic [NW-1:0] child;
    logic [SW-1:0] half;
    logic [LW-1:0] off_step;
    logic [NW-1:0] par;
    logic [SW-1:0] pns;
    logic [SW:0]   pair_sum;
    logic [SW-1:0] up_val;
    logic [SW-1:0] init_val;
    logic          init_last;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= tree_mem[mem_raddr];
        end
    end

    always_comb
    begin
        req32    = (page_count > CNT_W'(1)) ? (smear(32'(page_count) - 32'd1) + 32'd1) : 32'd1;
        cap32    = (32'(pages_in_use) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(pages_in_use);
        span32   = smear(cap32);
        init32   = span32 ^ (span32 >> 1);

        lchild   = NW'({idx_reg, 1'b1});
        go_left  = (rd_data_reg >= size_reg);
        child    = go_left ? lchild : (lchild + NW'(1));
        half     = ns_reg >> 1;
        off_step = go_left ? off_reg : (off_reg + LW'(half));

        par      = parent_of(idx_reg);
        pns      = ns_reg << 1;
        pair_sum = {1'b0, val_reg} + {1'b0, rd_data_reg};
        up_val   = (state_reg == S_FUP && pair_sum == {1'b0, pns}) ? pns
                                                                  : larger(val_reg, rd_data_reg);

        init_val  = (idx_reg != '0 && ((idx_reg + NW'(1)) & idx_reg) == '0) ? (ns_reg >> 1)
                                                                              : ns_reg;
        init_last = ({1'b0, idx_reg} == ({managed_reg, 1'b0} - (NW+1)'(2)));
    end

    always_comb
    begin
        state_next      = state_reg;
        managed_next    = managed_reg;
        free_next       = free_reg;
        root_next       = root_reg;
        idx_next        = idx_reg;
        ns_next         = ns_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_pages_next  = res_pages_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_off_next    = '0;
                    res_pages_next  = '0;
                    state_next      = S_DONE;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (req32 > 32'(managed_reg) || 32'(root_reg) < req32)
                            begin
                                res_status_next = ST_NO_SPACE;
                            end
                            else if (req32 == 32'(managed_reg))
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = '0;
                                mem_wdata      = '0;
                                root_next      = '0;
                                res_pages_next = managed_reg;
                                free_next      = free_reg - managed_reg;
                            end
                            else
                            begin
                                size_next  = SW'(req32);
                                idx_next   = '0;
                                ns_next    = managed_reg;
                                off_next   = '0;
                                mem_re     = 1'b1;
                                mem_raddr  = NW'(1);
                                state_next = S_ADESC;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (32'(block_offset) >= 32'(managed_reg))
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = NW'(block_offset) + NW'(managed_reg) - NW'(1);
                                ns_next    = SW'(1);
                                off_next   = LW'(block_offset);
                                mem_re     = 1'b1;
                                mem_raddr  = NW'(block_offset) + NW'(managed_reg) - NW'(1);
                                state_next = S_FCLIMB;
                            end
                        end
                        CMD_INIT:
                        begin
                            managed_next   = SW'(init32);
                            free_next      = SW'(init32);
                            root_next      = SW'(init32);
                            res_pages_next = SW'(init32);
                            if (init32 != 32'd0)
                            begin
                                idx_next   = '0;
                                ns_next    = SW'(init32);
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_ADESC:
            begin
                idx_next = child;
                ns_next  = half;
                off_next = off_step;
                if (half == size_reg)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = child;
                    mem_wdata      = '0;
                    val_next       = '0;
                    res_off_next   = off_step;
                    res_pages_next = half;
                    free_next      = free_reg - half;
                    mem_re         = 1'b1;
                    mem_raddr      = sibling_of(child);
                    state_next     = S_AUP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = NW'({child, 1'b1});
                end
            end
            S_FCLIMB:
            begin
                if (rd_data_reg == '0)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = idx_reg;
                    mem_wdata      = ns_reg;
                    val_next       = ns_reg;
                    res_off_next   = off_reg & ~LW'(ns_reg - SW'(1));
                    res_pages_next = ns_reg;
                    free_next      = free_reg + ns_reg;
                    if (idx_reg == '0)
                    begin
                        root_next  = ns_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = sibling_of(idx_reg);
                        state_next = S_FUP;
                    end
                end
                else if (idx_reg == '0)
                begin
                    res_status_next = ST_NOT_ALLOC;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next  = par;
                    ns_next   = pns;
                    mem_re    = 1'b1;
                    mem_raddr = par;
                end
            end
            S_AUP, S_FUP:
            begin
                mem_we    = 1'b1;
                mem_waddr = par;
                mem_wdata = up_val;
                val_next  = up_val;
                idx_next  = par;
                ns_next   = pns;
                if (par == '0)
                begin
                    root_next  = up_val;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = sibling_of(par);
                end
            end
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = init_val;
                ns_next   = init_val;
                if (init_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + NW'(1);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            managed_reg <= '0;
            free_reg    <= '0;
            root_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            managed_reg <= managed_next;
            free_reg    <= free_next;
            root_reg    <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        ns_reg         <= ns_next;
        size_reg       <= size_next;
        off_reg        <= off_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_pages_reg  <= res_pages_next;
    end

    assign res_valid         = (state_reg == S_DONE);
    assign res.status        = res_status_reg;
    assign res.result_offset = OFF_W'(res_off_reg);
    assign res.block_pages   = CNT_W'(res_pages_reg);
    assign res.pages_left    = CNT_W'(free_reg);

    assign stat.idle       = (state_reg == S_IDLE);
    assign stat.pages_left = CNT_W'(free_reg);
    assign stat.managed    = CNT_W'(managed_reg);

endmodule
`default_nettype wire

@@ sv/buddy_page_allocator.sv @@
`default_nettype none
// top level of the buddy page allocator: stream ports, register port and result buffer
//
// one command beat is taken at a time; its result beat sits in an output register so the
// next command is accepted while the result waits. the tree lives in one memory with one
// write and one read port and is walked one level per cycle: with L = log2 of the managed
// size, allocate descends the tree and then refreshes the ancestors, free climbs to the
// allocated node and merges back to the root (together these cover L + 1 levels), and
// initialize writes one tree node per cycle. a free of a page that is not allocated climbs
// to the root first. a finished result that finds the output register still held holds the
// block until that beat leaves.
// before the first initialize the tree is empty: allocate answers no space and free
// answers offset out of range.
module buddy_page_allocator import bpa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // page_count, block_offset
    input  wire  [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status, result_offset, block_pages, pages_left
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_PAGES = 1'b0;

    logic [CNT_W-1:0] pages_reg, pages_next;
    logic             out_valid_reg, out_valid_next;
    logic [39:0]      out_data_reg;

    logic      res_valid;
    logic      res_take;
    bpa_res_t  res;
    bpa_stat_t stat;

    bpa_engine #(
        .MAX_PAGES (MAX_PAGES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .cmd          (s_axis_tuser),
        .page_count   (s_axis_tdata[10:0]),
        .block_offset (s_axis_tdata[20:11]),
        .pages_in_use (pages_reg),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .stat         (stat)
    );

    assign s_axis_tready = stat.idle;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_PAGES) ? 32'(pages_reg) : 32'd0;

    always_comb
    begin
        pages_next = pages_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_PAGES)
        begin
            pages_next = pwdata[CNT_W-1:0];
        end
    end

    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg     <= PAGES_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pages_reg     <= pages_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= {6'd0, res.pages_left, res.block_pages, res.result_offset, res.status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_free_le_managed: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pages_left <= stat.managed)
        else $error("free page count exceeds managed size");

    a_managed_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stat.managed))
        else $error("managed size is not a power of two");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while previous command still in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result beat overwritten");
`endif

endmodule
`default_nettype wire
